// ===== hw/rtl/hbd_pkg.sv =====
// Package for the Huffman bit decoder: beat payload types, opcodes and field widths.
// Has no dependencies; every module of the decoder imports it.
package hbd_pkg;

    localparam int SYM_W      = 8;
    localparam int CODE_W     = 12;
    localparam int LEN_W      = 4;
    localparam int FIELD_W    = 20;
    localparam int HIST_DEPTH = 256;
    localparam int HIST_AW    = 8;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
        logic [SYM_W-1:0]  entry_symbol;
        logic              code_bit;
    } t_in_item;

    typedef struct packed {
        logic               symbol_valid;
        logic [SYM_W-1:0]   decoded_symbol;
        logic [FIELD_W-1:0] symbol_count;
        logic [FIELD_W-1:0] bits_consumed;
        logic [FIELD_W-1:0] symbols_decoded;
        logic               overflow_error;
    } t_out_item;

    // Outcome of one table lookup, passed from the walk stage to the count stage
    typedef struct packed {
        logic             valid;
        logic             decode;
        logic             hit;
        logic             ovf;
        logic [SYM_W-1:0] leaf;
    } t_walk_res;

endpackage

// ===== hw/rtl/hbd_leaf_walk.sv =====
// Leaf table memory and tree walk position of the Huffman bit decoder.
// Depends on hbd_pkg.
module hbd_leaf_walk
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    input  logic                  i_clr_en,
    input  logic [MAX_CODE_LEN:0] i_clr_addr,
    output t_walk_res             o_res
);

    localparam int TBL_AW     = MAX_CODE_LEN + 1;
    localparam int TBL_DEPTH  = 1 << TBL_AW;
    localparam int CODE_EXT_W = TBL_AW + CODE_W;

    logic [SYM_W-1:0]        mem [TBL_DEPTH];
    logic [SYM_W-1:0]        r_leaf;
    logic [MAX_CODE_LEN-1:0] r_walk;
    logic                    r_s2_valid;
    logic                    r_s2_decode;
    logic [TBL_AW-1:0]       r_s2_pos;

    logic                    s2_hit;
    logic                    s2_ovf;
    logic [MAX_CODE_LEN-1:0] s2_next_walk;
    logic [MAX_CODE_LEN-1:0] cur_walk;
    logic [TBL_AW-1:0]       rd_addr;
    logic                    rd_en;
    logic [TBL_AW-1:0]       ld_addr;
    logic                    ld_we;
    logic [CODE_EXT_W-1:0]   code_ext;

    // Resolve the lookup that is back from the table
    assign s2_hit       = r_s2_decode && (r_leaf != '0);
    assign s2_ovf       = r_s2_decode && (r_leaf == '0) && r_s2_pos[TBL_AW-1];
    assign s2_next_walk = (s2_hit || s2_ovf) ? MAX_CODE_LEN'(1)
                                             : r_s2_pos[MAX_CODE_LEN-1:0];

    // Forward the fresh position so that the next bit may follow at once
    assign cur_walk = (r_s2_valid && r_s2_decode) ? s2_next_walk : r_walk;
    assign rd_addr  = {cur_walk, i_item.code_bit};
    assign rd_en    = i_accept && (i_item.operation == OP_DECODE);
    assign ld_we    = i_accept && (i_item.operation == OP_LOAD) &&
                      (int'(i_item.code_length) <= MAX_CODE_LEN);

    // Leaf index: marker bit at the code length, code bits below it
    always_comb begin
        code_ext = CODE_EXT_W'(i_item.code_bits);
        for (int j = 0; j < TBL_AW; j++) begin
            if (j == int'(i_item.code_length)) begin
                ld_addr[j] = 1'b1;
            end else if (j < int'(i_item.code_length)) begin
                ld_addr[j] = code_ext[j];
            end else begin
                ld_addr[j] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            mem[i_clr_addr] <= '0;
        end else if (ld_we) begin
            mem[ld_addr] <= i_item.entry_symbol;
        end
        if (rd_en) begin
            r_leaf <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk     <= MAX_CODE_LEN'(1);
            r_s2_valid <= 1'b0;
        end else if (i_adv) begin
            r_s2_valid <= i_accept;
            if (r_s2_valid && r_s2_decode) begin
                r_walk <= s2_next_walk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2_decode <= (i_item.operation == OP_DECODE);
            r_s2_pos    <= rd_addr;
        end
    end

    assign o_res.valid  = r_s2_valid;
    assign o_res.decode = r_s2_decode;
    assign o_res.hit    = s2_hit;
    assign o_res.ovf    = s2_ovf;
    assign o_res.leaf   = s2_hit ? r_leaf : '0;

    a_walk_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk != '0)
        else $error("walk position left the tree");

    a_clear_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_en |-> !i_accept)
        else $error("beat accepted during table clear");

endmodule

// ===== hw/rtl/hbd_hist_count.sv =====
// Symbol histogram memory, saturating totals and result assembly of the decoder.
// Depends on hbd_pkg.
module hbd_hist_count
    import hbd_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_walk_res          i_res,
    input  logic               i_clr_en,
    input  logic [HIST_AW-1:0] i_clr_addr,
    output logic               o_valid,
    output t_out_item          o_item
);

    logic [COUNT_BITS-1:0] mem [HIST_DEPTH];
    logic [COUNT_BITS-1:0] r_hist_q;
    logic                  r_s3_valid;
    logic                  r_s3_decode;
    logic                  r_s3_hit;
    logic                  r_s3_ovf;
    logic [SYM_W-1:0]      r_s3_leaf;
    logic                  r_fwd_valid;
    logic [SYM_W-1:0]      r_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data;
    logic [COUNT_BITS-1:0] r_bit_total;
    logic [COUNT_BITS-1:0] r_sym_total;

    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] n_bit_total;
    logic [COUNT_BITS-1:0] n_sym_total;
    logic                  hist_we;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [COUNT_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[FIELD_W-1:0];
    endfunction

    // Take the last written count when the read raced that write
    assign cur_count   = (r_fwd_valid && (r_fwd_addr == r_s3_leaf)) ? r_fwd_data : r_hist_q;
    assign n_count     = sat_inc(cur_count);
    assign n_bit_total = r_s3_decode ? sat_inc(r_bit_total) : r_bit_total;
    assign n_sym_total = r_s3_hit ? sat_inc(r_sym_total) : r_sym_total;
    assign hist_we     = i_adv && r_s3_valid && r_s3_hit;

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            mem[i_clr_addr] <= '0;
        end else if (hist_we) begin
            mem[r_s3_leaf] <= n_count;
        end
        if (i_adv && i_res.valid && i_res.hit) begin
            r_hist_q <= mem[i_res.leaf];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_bit_total <= '0;
            r_sym_total <= '0;
        end else if (i_adv) begin
            r_s3_valid <= i_res.valid;
            if (hist_we) begin
                r_fwd_valid <= 1'b1;
            end
            if (r_s3_valid) begin
                r_bit_total <= n_bit_total;
                r_sym_total <= n_sym_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s3_decode <= i_res.decode;
            r_s3_hit    <= i_res.hit;
            r_s3_ovf    <= i_res.ovf;
            r_s3_leaf   <= i_res.leaf;
            if (hist_we) begin
                r_fwd_addr <= r_s3_leaf;
                r_fwd_data <= n_count;
            end
        end
    end

    assign o_valid               = r_s3_valid;
    assign o_item.symbol_valid   = r_s3_hit;
    assign o_item.decoded_symbol = r_s3_hit ? r_s3_leaf : '0;
    assign o_item.symbol_count   = r_s3_hit ? to_field(n_count) : '0;
    assign o_item.bits_consumed  = to_field(n_bit_total);
    assign o_item.symbols_decoded = to_field(n_sym_total);
    assign o_item.overflow_error = r_s3_ovf;

    a_hit_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_valid && r_s3_hit) |-> (n_count != '0))
        else $error("decoded symbol reports a zero count");

    a_totals_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym_total <= r_bit_total)
        else $error("more symbols than bits decoded");

endmodule

// ===== hw/rtl/huffman_bit_decoder.sv =====
// Huffman bit decoder: one input beat per cycle unless stalled, one result each.
// Pipe: three register stages (leaf table read, histogram read, output register);
// an accepted input beat passes them in order before its result beat is offered.
// Throughput: one beat per cycle unless stalled; the next bit's table address
// is formed from the previous bit's leaf read data in the cycle that data arrives.
// Reset: a clearing pass zeroes every entry of the leaf table and histogram;
// no beat is accepted until it ends.
module huffman_bit_decoder
    import hbd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 12,
    parameter int COUNT_BITS   = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int TBL_AW    = MAX_CODE_LEN + 1;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int CLR_DEPTH = (TBL_DEPTH > HIST_DEPTH) ? TBL_DEPTH : HIST_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);

    logic              r_clearing;
    logic [CLR_AW-1:0] r_clr_addr;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              adv;
    logic              accept;
    t_walk_res         walk_res;
    logic              s3_valid;
    t_out_item         s3_item;

    // The whole pipe moves together whenever the output register can take a beat;
    // bubbles travel with it, so a free output slot never blocks the input.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clearing || !adv;
    assign accept     = i_in_valid && !o_in_stall;

    // Clearing pass after reset: sweep one table entry and one histogram entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + CLR_AW'(1);
            if (r_clr_addr == CLR_AW'(CLR_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Stage one and two: table write or lookup, walk position update
    hbd_leaf_walk #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_clr_en   (r_clearing),
        .i_clr_addr (r_clr_addr[TBL_AW-1:0]),
        .o_res      (walk_res)
    );

    // Stage three: histogram read-modify-write, totals, result assembly
    hbd_hist_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_res      (walk_res),
        .i_clr_en   (r_clearing),
        .i_clr_addr (r_clr_addr[HIST_AW-1:0]),
        .o_valid    (s3_valid),
        .o_item     (s3_item)
    );

    // Output register: hold the beat while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= s3_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule
